[rtl/rhps_pkg.sv]
// Package with shared widths, register indexes and the reduction unit's command types.
`timescale 1ns / 1ps
`default_nettype none

package rhps_pkg;

    // Field and register widths.
    localparam int BYTE_W        = 8;
    localparam int HASH_W        = 16;
    localparam int POS_W         = 16;
    localparam int PATTERN_W     = 64;
    localparam int LEN_W         = 4;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_IDX_W     = 2;

    // Default window depth: the longest pattern supported.
    localparam int MAX_PATTERN_DEF = 8;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PATTERN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LENGTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PRIME   = 2'd2;

    // Reset values of the registers.
    localparam logic [PATTERN_W-1:0] PATTERN_RST = '0;
    localparam logic [LEN_W-1:0]     LENGTH_RST  = 4'd1;
    localparam logic [HASH_W-1:0]    PRIME_RST   = 16'd101;

    // Smallest modulus the hash accepts.
    localparam logic [HASH_W-1:0]    PRIME_MIN   = 16'd2;

    // Request to the modular reduction unit: reduce (init * 256 + data) mod prime,
    // where init is already below the prime.
    typedef struct packed {
        logic              go;
        logic [HASH_W-1:0] init;
        logic [BYTE_W-1:0] data;
    } t_red_cmd;

    // Answer of the reduction unit; done pulses for one cycle.
    typedef struct packed {
        logic              done;
        logic [HASH_W-1:0] rem;
    } t_red_rsp;

endpackage

`default_nettype wire

[rtl/rhps_modred.sv]
// Shared modular reduction unit: shifts one byte into a remainder, two bits per cycle.
`timescale 1ns / 1ps
`default_nettype none

module rhps_modred
    import rhps_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [HASH_W-1:0] i_prime,
    input  wire t_red_cmd          i_cmd,
    output t_red_rsp               o_rsp
);

    // Two restoring steps per cycle.
    localparam int BITS_PER_CYCLE = 2;
    localparam int STEPS          = BYTE_W / BITS_PER_CYCLE;
    localparam int CNT_W          = $clog2(STEPS);

    logic [HASH_W-1:0] r_rem;
    logic [BYTE_W-1:0] r_data;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    // One restoring step: double the remainder, bring in a bit, take off the prime once.
    function automatic logic [HASH_W-1:0] red_step(
        input logic [HASH_W-1:0] rem,
        input logic              bit_in,
        input logic [HASH_W-1:0] prime
    );
        logic [HASH_W:0] t;
        t = {rem, bit_in};
        if (t >= {1'b0, prime}) begin
            t = t - {1'b0, prime};
        end
        return t[HASH_W-1:0];
    endfunction

    function automatic logic [HASH_W-1:0] two_steps(
        input logic [HASH_W-1:0] rem,
        input logic [1:0]        bits,
        input logic [HASH_W-1:0] prime
    );
        logic [HASH_W-1:0] mid;
        mid = red_step(rem, bits[1], prime);
        return red_step(mid, bits[0], prime);
    endfunction

    // Sequencing of the step cycles.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.go) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(1);
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder and the bits still to be shifted in.
    always_ff @(posedge i_clk) begin
        if (i_cmd.go) begin
            r_rem  <= two_steps(i_cmd.init, i_cmd.data[BYTE_W-1 -: BITS_PER_CYCLE], i_prime);
            r_data <= {i_cmd.data[BYTE_W-BITS_PER_CYCLE-1:0], {BITS_PER_CYCLE{1'b0}}};
        end else if (r_busy) begin
            r_rem  <= two_steps(r_rem, r_data[BYTE_W-1 -: BITS_PER_CYCLE], i_prime);
            r_data <= {r_data[BYTE_W-BITS_PER_CYCLE-1:0], {BITS_PER_CYCLE{1'b0}}};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

`default_nettype wire

[rtl/rolling_hash_pattern_search_top.sv]
// Top level of the rolling hash pattern search: sequencer, window, registers and output stage.
`timescale 1ns / 1ps
`default_nettype none

// Streaming Rabin-Karp search. Text arrives one byte per input item; a match of the
// configured pattern gives one result item with the zero-based start position. All
// modular reduction but the subtraction of the outgoing term runs through one shared
// reduction unit, and an item needs two passes of it; no new item is taken until the
// last one is through. For the first item after a write of the prime, unless it starts
// a new text, the stored window hash is first reduced by the new prime in two more
// passes. After reset and after every register write the block derives the pattern
// hash and the outgoing weight; input is stalled meanwhile. A result waiting on a
// stalled output does not hold up the next item until that item itself finds a match.
module rolling_hash_pattern_search_top
    import rhps_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Configuration write port.
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // Input item channel.
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [BYTE_W-1:0]     i_text_byte,
    input  wire logic                  i_first_of_text,
    // Result item channel.
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [POS_W-1:0]           o_match_position
);

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int K_W   = $clog2(MAX_PATTERN + 1);

    typedef enum logic [3:0] {
        S_DERIVE,
        S_W_WAIT,
        S_P_WAIT,
        S_IDLE,
        S_HH_WAIT,
        S_HL_WAIT,
        S_MUL,
        S_S_WAIT,
        S_F_WAIT,
        S_CHECK,
        S_HOLD
    } t_state;

    t_state             r_state;

    // Configuration registers.
    logic [PATTERN_W-1:0] r_pat;
    logic [LEN_W-1:0]     r_len;
    logic [HASH_W-1:0]    r_prime;

    // Search state.
    logic [BYTE_W-1:0]  r_win [MAX_PATTERN];
    logic [POS_W-1:0]   r_count;
    logic [HASH_W-1:0]  r_whash;
    logic [HASH_W-1:0]  r_phash;
    logic [HASH_W-1:0]  r_weight;
    logic               r_hred;

    // Working registers of the current item.
    logic [BYTE_W-1:0]  r_byte;
    logic [HASH_W-1:0]  r_hsh;
    logic [K_W-1:0]     r_k;
    t_red_cmd           r_cmd;
    t_red_rsp           w_rsp;

    logic               r_out_valid;
    logic [POS_W-1:0]   r_out_pos;

    logic [K_W-1:0]        w_m;
    logic [HASH_W-1:0]     w_p;
    logic                  w_full;
    logic [IDX_W-1:0]      w_tap;
    logic [BYTE_W+HASH_W-1:0] w_prod;
    logic [HASH_W-1:0]     w_diff;
    logic                  w_hit;
    logic                  w_out_free;
    logic [POS_W-1:0]      w_pos;

    function automatic logic [BYTE_W-1:0] pat_char(
        input logic [PATTERN_W-1:0] pat,
        input logic [2:0]           k
    );
        return pat[BYTE_W*k +: BYTE_W];
    endfunction

    // Effective length and prime, clamped to their usable ranges.
    always_comb begin
        if (r_len == '0) begin
            w_m = K_W'(1);
        end else if (r_len > LEN_W'(MAX_PATTERN)) begin
            w_m = K_W'(MAX_PATTERN);
        end else begin
            w_m = K_W'(r_len);
        end
        w_p = (r_prime < PRIME_MIN) ? PRIME_MIN : r_prime;
    end

    assign w_full = (r_count >= POS_W'(w_m));
    assign w_tap  = IDX_W'(w_m - K_W'(1));

    // Weighted outgoing byte; zero while the window is not yet full.
    assign w_prod = w_full ? ({{HASH_W{1'b0}}, r_win[w_tap]} * {{BYTE_W{1'b0}}, r_weight})
                           : '0;

    // Window hash minus the reduced outgoing term, brought back below the prime.
    always_comb begin
        logic [HASH_W:0] t;
        t = {1'b0, r_hsh} + {1'b0, w_p} - {1'b0, w_rsp.rem};
        if (t >= {1'b0, w_p}) begin
            t = t - {1'b0, w_p};
        end
        w_diff = t[HASH_W-1:0];
    end

    // Full window, equal hashes and a byte-by-byte check, one lane per character.
    always_comb begin
        logic [K_W-1:0] idx;
        w_hit = w_full && (r_whash == r_phash);
        for (int j = 0; j < MAX_PATTERN; j++) begin
            idx = w_m - K_W'(1) - K_W'(j);
            if (K_W'(j) < w_m) begin
                if (r_win[idx[IDX_W-1:0]] != pat_char(r_pat, 3'(j))) begin
                    w_hit = 1'b0;
                end
            end
        end
    end

    assign w_pos      = r_count - POS_W'(w_m);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Sequencer with its registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_DERIVE;
            r_pat       <= PATTERN_RST;
            r_len       <= LENGTH_RST;
            r_prime     <= PRIME_RST;
            for (int j = 0; j < MAX_PATTERN; j++) begin
                r_win[j] <= '0;
            end
            r_count     <= '0;
            r_whash     <= '0;
            r_phash     <= '0;
            r_weight    <= '0;
            r_hred      <= 1'b1;
            r_k         <= '0;
            r_cmd       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cmd.go <= 1'b0;

            // The waiting result leaves when the receiver takes it.
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                // Start of derivation: outgoing weight first, then the pattern hash.
                S_DERIVE: begin
                    r_weight <= HASH_W'(1);
                    r_k      <= K_W'(1);
                    if (w_m > K_W'(1)) begin
                        r_cmd   <= '{go: 1'b1, init: HASH_W'(1), data: '0};
                        r_state <= S_W_WAIT;
                    end else begin
                        r_cmd   <= '{go: 1'b1, init: '0, data: pat_char(r_pat, 3'd0)};
                        r_state <= S_P_WAIT;
                    end
                end

                S_W_WAIT: begin
                    if (w_rsp.done) begin
                        r_weight <= w_rsp.rem;
                        if (r_k == w_m - K_W'(1)) begin
                            r_cmd   <= '{go: 1'b1, init: '0, data: pat_char(r_pat, 3'd0)};
                            r_k     <= K_W'(1);
                            r_state <= S_P_WAIT;
                        end else begin
                            r_cmd <= '{go: 1'b1, init: w_rsp.rem, data: '0};
                            r_k   <= r_k + K_W'(1);
                        end
                    end
                end

                S_P_WAIT: begin
                    if (w_rsp.done) begin
                        if (r_k == w_m) begin
                            r_phash <= w_rsp.rem;
                            r_state <= S_IDLE;
                        end else begin
                            r_cmd <= '{go: 1'b1, init: w_rsp.rem,
                                       data: pat_char(r_pat, 3'(r_k))};
                            r_k   <= r_k + K_W'(1);
                        end
                    end
                end

                // Take an item; a new text clears the window, count and hash.
                S_IDLE: begin
                    if (i_in_valid && !i_cfg_we) begin
                        r_byte <= i_text_byte;
                        if (i_first_of_text) begin
                            for (int j = 0; j < MAX_PATTERN; j++) begin
                                r_win[j] <= '0;
                            end
                            r_count <= '0;
                            r_whash <= '0;
                            r_hsh   <= '0;
                            r_hred  <= 1'b1;
                            r_state <= S_MUL;
                        end else if (r_hred) begin
                            r_hsh   <= r_whash;
                            r_state <= S_MUL;
                        end else begin
                            r_cmd   <= '{go: 1'b1, init: '0, data: r_whash[HASH_W-1 -: BYTE_W]};
                            r_state <= S_HH_WAIT;
                        end
                    end
                end

                // Stored hash reduced by a changed prime, high byte then low byte.
                S_HH_WAIT: begin
                    if (w_rsp.done) begin
                        r_cmd   <= '{go: 1'b1, init: w_rsp.rem, data: r_whash[BYTE_W-1:0]};
                        r_state <= S_HL_WAIT;
                    end
                end

                S_HL_WAIT: begin
                    if (w_rsp.done) begin
                        r_hsh   <= w_rsp.rem;
                        r_state <= S_MUL;
                    end
                end

                // Outgoing byte times weight; the high part is already below the prime.
                S_MUL: begin
                    r_cmd   <= '{go: 1'b1, init: w_prod[BYTE_W +: HASH_W],
                                 data: w_prod[BYTE_W-1:0]};
                    r_state <= S_S_WAIT;
                end

                S_S_WAIT: begin
                    if (w_rsp.done) begin
                        r_cmd   <= '{go: 1'b1, init: w_diff, data: r_byte};
                        r_state <= S_F_WAIT;
                    end
                end

                // New hash is in: shift the window and count the byte.
                S_F_WAIT: begin
                    if (w_rsp.done) begin
                        r_whash <= w_rsp.rem;
                        r_hred  <= 1'b1;
                        for (int j = MAX_PATTERN - 1; j > 0; j--) begin
                            r_win[j] <= r_win[j-1];
                        end
                        r_win[0] <= r_byte;
                        if (r_count != {POS_W{1'b1}}) begin
                            r_count <= r_count + POS_W'(1);
                        end
                        r_state <= S_CHECK;
                    end
                end

                S_CHECK: begin
                    if (!w_hit) begin
                        r_state <= S_IDLE;
                    end else if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_pos   <= w_pos;
                        r_state     <= S_IDLE;
                    end else begin
                        r_state <= S_HOLD;
                    end
                end

                // Match found while the previous result still waits.
                S_HOLD: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_pos   <= w_pos;
                        r_state     <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_DERIVE;
                end
            endcase

            // Register writes restart the derivation. The shared unit is restarted too,
            // so that a pass cut short by the write never reports its answer.
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_IDX_PATTERN: begin
                        r_pat   <= i_cfg_data[PATTERN_W-1:0];
                        r_cmd.go <= 1'b1;
                        r_state <= S_DERIVE;
                    end
                    CFG_IDX_LENGTH: begin
                        r_len   <= i_cfg_data[LEN_W-1:0];
                        r_cmd.go <= 1'b1;
                        r_state <= S_DERIVE;
                    end
                    CFG_IDX_PRIME: begin
                        r_prime <= i_cfg_data[HASH_W-1:0];
                        r_hred  <= 1'b0;
                        r_cmd.go <= 1'b1;
                        r_state <= S_DERIVE;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Shared reduction unit.
    rhps_modred u_modred (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_prime (w_p),
        .i_cmd   (r_cmd),
        .o_rsp   (w_rsp)
    );

    // Input waits while busy and while a register is being written.
    assign o_in_stall       = (r_state != S_IDLE) || i_cfg_we;
    assign o_out_valid      = r_out_valid;
    assign o_match_position = r_out_pos;

endmodule

`default_nettype wire
